FILE: rtl/mse_pkg.sv
package mse_pkg;

    localparam int DATA_W = 32;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_LOAD     = 6'b000001,
        ST_RUN      = 6'b000010,
        ST_FETCH    = 6'b000100,
        ST_MERGE    = 6'b001000,
        ST_OUT_RD   = 6'b010000,
        ST_OUT_SEND = 6'b100000
    } state_t;

endpackage

FILE: rtl/merge_sort_engine.sv
// channel  | dir | tdata                        | tlast      | tuser
// ---------+-----+------------------------------+------------+-----------
// s_       | in  | [31:0] value (signed)        | is_last    | -
// m_       | out | [31:0] sorted_value (signed) | end_of_run | overflowed
//
// loading takes one beat per cycle; the beat with tlast starts the sort
// bottom-up merge passes through one shared compare unit, ping-ponging two banks:
// a FETCH and a MERGE state per element moved, a RUN state per run pair and per pass
// each result takes an OUT_RD and an OUT_SEND state; s_tready is low from the last loaded beat
// until the final result beat is taken; stalls on m_ hold the beat unchanged
// rst_n is asynchronous; the banks hold no reset and are read only where written
module merge_sort_engine #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [mse_pkg::DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                       s_tlast,   // is_last
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mse_pkg::DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic                       m_tlast,   // end_of_run
    output logic                       m_tuser    // overflowed
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    // index width: room for lo + 2*width without wrapping
    localparam int IDX_W = AW + 2;

    mse_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             src_reg, src_next;       // bank holding the current runs
    logic [IDX_W-1:0] width_reg, width_next;   // run width of this pass
    logic [IDX_W-1:0] lo_reg, lo_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] i_reg, i_next;           // left head, also output index
    logic [IDX_W-1:0] j_reg, j_next;           // right head
    logic [IDX_W-1:0] k_reg, k_next;           // write index

    // two banks, one write and two registered reads each
    logic [mse_pkg::DATA_W-1:0] bank0 [DEPTH];
    logic [mse_pkg::DATA_W-1:0] bank1 [DEPTH];
    logic [mse_pkg::DATA_W-1:0] bank0_a_reg, bank0_b_reg;
    logic [mse_pkg::DATA_W-1:0] bank1_a_reg, bank1_b_reg;

    logic                       bank0_we, bank1_we;
    logic [AW-1:0]              wr_addr;
    logic [mse_pkg::DATA_W-1:0] wr_data;

    logic                       in_beat, out_beat, full;
    logic [IDX_W-1:0]           n_ext, lo_plus_w, lo_plus_2w, width_dbl;
    logic [mse_pkg::DATA_W-1:0] head_a, head_b;
    logic                       take_left;
    logic [CNT_W-1:0]           load_cnt;

    assign n_ext    = {{(IDX_W-CNT_W){1'b0}}, count_reg};
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // count after the current input beat
    assign load_cnt = full ? count_reg : count_reg + 1'b1;

    // run bounds for the next pair of runs
    assign lo_plus_w  = lo_reg + width_reg;
    assign lo_plus_2w = lo_reg + (width_reg << 1);
    assign width_dbl  = width_reg << 1;

    // shared compare unit: left wins when strictly smaller or when the right run is used up
    assign head_a    = src_reg ? bank1_a_reg : bank0_a_reg;
    assign head_b    = src_reg ? bank1_b_reg : bank0_b_reg;
    assign take_left = (i_reg < mid_reg) &&
                       ((j_reg >= hi_reg) || ($signed(head_a) < $signed(head_b)));

    // bank write steering: loading fills bank0, merges write the other bank
    always_comb
    begin
        bank0_we = 1'b0;
        bank1_we = 1'b0;
        wr_addr  = k_reg[AW-1:0];
        wr_data  = take_left ? head_a : head_b;
        if (state_reg == mse_pkg::ST_LOAD)
        begin
            bank0_we = in_beat && !full;
            wr_addr  = count_reg[AW-1:0];
            wr_data  = s_tdata;
        end
        else if (state_reg == mse_pkg::ST_MERGE)
        begin
            bank0_we = src_reg;
            bank1_we = !src_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bank0_we)
        begin
            bank0[wr_addr] <= wr_data;
        end
        bank0_a_reg <= bank0[i_reg[AW-1:0]];
        bank0_b_reg <= bank0[j_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (bank1_we)
        begin
            bank1[wr_addr] <= wr_data;
        end
        bank1_a_reg <= bank1[i_reg[AW-1:0]];
        bank1_b_reg <= bank1[j_reg[AW-1:0]];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        src_next   = src_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;

        unique case (state_reg)
            mse_pkg::ST_LOAD:
            begin
                if (in_beat)
                begin
                    count_next = load_cnt;
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        src_next   = 1'b0;
                        width_next = IDX_W'(1);
                        lo_next    = '0;
                        i_next     = '0;
                        // a single value needs no pass
                        if (load_cnt == CNT_W'(1))
                        begin
                            state_next = mse_pkg::ST_OUT_RD;
                        end
                        else
                        begin
                            state_next = mse_pkg::ST_RUN;
                        end
                    end
                end
            end

            mse_pkg::ST_RUN:
            begin
                if (lo_reg >= n_ext)
                begin
                    // pass done, the merged runs sit in the other bank
                    src_next = !src_reg;
                    if (width_dbl >= n_ext)
                    begin
                        i_next     = '0;
                        state_next = mse_pkg::ST_OUT_RD;
                    end
                    else
                    begin
                        width_next = width_dbl;
                        lo_next    = '0;
                    end
                end
                else
                begin
                    mid_next   = (lo_plus_w < n_ext) ? lo_plus_w : n_ext;
                    hi_next    = (lo_plus_2w < n_ext) ? lo_plus_2w : n_ext;
                    i_next     = lo_reg;
                    j_next     = (lo_plus_w < n_ext) ? lo_plus_w : n_ext;
                    k_next     = lo_reg;
                    state_next = mse_pkg::ST_FETCH;
                end
            end

            mse_pkg::ST_FETCH:
            begin
                // heads are read this cycle
                state_next = mse_pkg::ST_MERGE;
            end

            mse_pkg::ST_MERGE:
            begin
                if (take_left)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
                k_next = k_reg + 1'b1;
                if (k_reg + 1'b1 == hi_reg)
                begin
                    lo_next    = hi_reg;
                    state_next = mse_pkg::ST_RUN;
                end
                else
                begin
                    state_next = mse_pkg::ST_FETCH;
                end
            end

            mse_pkg::ST_OUT_RD:
            begin
                state_next = mse_pkg::ST_OUT_SEND;
            end

            mse_pkg::ST_OUT_SEND:
            begin
                if (out_beat)
                begin
                    if (m_tlast)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = mse_pkg::ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = mse_pkg::ST_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = mse_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mse_pkg::ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            src_reg   <= 1'b0;
            width_reg <= '0;
            lo_reg    <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            src_reg   <= src_next;
            width_reg <= width_next;
            lo_reg    <= lo_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // ports
    assign s_tready = (state_reg == mse_pkg::ST_LOAD);
    assign m_tvalid = (state_reg == mse_pkg::ST_OUT_SEND);
    assign m_tdata  = head_a;                         // registered read of the final bank
    assign m_tlast  = (i_reg + 1'b1 == n_ext);
    assign m_tuser  = ovf_reg;

endmodule

FILE: rtl/mse_checker.sv
module mse_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       s_tlast,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [mse_pkg::DATA_W-1:0] m_tdata,
    input logic                       m_tlast,
    input logic                       m_tuser
);

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is offered");

    // a closing input beat starts the sort, input closes
    a_sort_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still ready after the last beat");

    // the final result beat reopens the input
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("input not ready after the final result");

    // overflow flag holds across a whole run of results
    a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !(m_tready && m_tlast)) |=> $stable(m_tuser))
        else $error("overflow flag changed inside a run");

    // a stalled beat keeps its data
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result beat changed");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
